// ===== rtl/kvbt_pkg.sv =====
// Shared types and constants for the key/value binding table.
package kvbt_pkg;

	localparam int KEY_W      = 32;
	localparam int OP_W       = 3;
	localparam int MAXC_W     = 4;
	localparam int OCCD_W     = 4;

	localparam int IN_BITS     = OP_W + 2 * KEY_W + MAXC_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 1 + 2 * KEY_W + OCCD_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

	localparam logic [MAXC_W-1:0] MAXC_CAP = 4'd8;
	localparam logic [OCCD_W-1:0] OCC_SAT  = 4'd15;

	typedef enum logic [OP_W-1:0] {
		OP_BIND   = 3'd0,
		OP_UNBIND = 3'd1,
		OP_LOOKUP = 3'd2,
		OP_ENUM   = 3'd3,
		OP_COUNT  = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ENUM
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input word, compare keys
		logic exec;       // run the captured operation
		logic enum_step;  // examine one slot of an enumerate walk
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // output register can take a word this cycle
		logic to_enum;    // captured op is an enumerate with entries to emit
		logic enum_last;  // enumerate emits its final word this cycle
	} stat_t;

endpackage

// ===== rtl/kvbt_ctrl.sv =====
// Sequencing state machine for the key/value binding table.
module kvbt_ctrl import kvbt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_tready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.to_enum) begin
					state_d = ST_ENUM;
				end else if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_ENUM: begin
				cmd.enum_step = 1'b1;
				if (stat.enum_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/kvbt_datapath.sv =====
// Slot storage, key compare, occupancy count, enumerate walk and output register.
module kvbt_datapath import kvbt_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OCC_W = $clog2(SLOTS + 1);

	// slot storage
	logic [KEY_W-1:0] key_q [SLOTS];
	logic [KEY_W-1:0] val_q [SLOTS];
	logic [OCC_W-1:0] occ_q;

	// captured input word
	op_t              op_q;
	logic [KEY_W-1:0] child_q;
	logic [KEY_W-1:0] peer_q;
	logic [MAXC_W-1:0] maxc_q;
	logic [SLOTS-1:0] match_q;
	logic [SLOTS-1:0] free_q;

	// enumerate walk
	logic [IDX_W-1:0]  cursor_q;
	logic [MAXC_W-1:0] ecnt_q;

	// output register
	logic              m_tvalid_q;
	logic              ok_q;
	logic [KEY_W-1:0]  och_q;
	logic [KEY_W-1:0]  ope_q;
	logic [OCCD_W-1:0] oocc_q;
	logic              olast_q;

	logic [MAXC_W-1:0] in_maxc;
	logic [KEY_W-1:0]  in_child;
	logic [SLOTS-1:0]  occ_vec;
	logic [SLOTS-1:0]  above;
	logic              out_free;
	logic              hit;
	logic              has_free;
	logic [IDX_W-1:0]  hit_idx;
	logic [IDX_W-1:0]  free_idx;
	logic              child_nz;
	logic              peer_nz;
	logic              enum_empty;
	logic              to_enum;
	logic              exec_do;
	logic              enum_emit;
	logic              e_last;
	logic [OCCD_W-1:0] occ_disp;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [KEY_W-1:0]  wr_key;
	logic [KEY_W-1:0]  wr_val;
	logic              clr_all;
	logic              occ_inc;
	logic              occ_dec;
	logic              res_ok;
	logic [KEY_W-1:0]  res_peer;
	logic [OCCD_W-1:0] res_occ;

	assign in_child = s_tdata[OP_W +: KEY_W];
	assign in_maxc  = s_tdata[OP_W + 2 * KEY_W +: MAXC_W];

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			occ_vec[i] = (key_q[i] != '0);
		end
	end

	// lowest set bit of each compare vector
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (free_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign out_free   = !m_tvalid_q || m_tready;
	assign hit        = |match_q;
	assign has_free   = |free_q;
	assign child_nz   = (child_q != '0);
	assign peer_nz    = (peer_q != '0);
	assign enum_empty = (maxc_q == '0) || (occ_q == '0);
	assign to_enum    = (op_q == OP_ENUM) && !enum_empty;
	assign exec_do    = cmd.exec && out_free && !to_enum;

	assign occ_disp = (32'(occ_q) > 32'(OCC_SAT)) ? OCC_SAT : OCCD_W'(occ_q);

	// enumerate: emit when the slot under the cursor is occupied
	assign above     = (occ_vec >> cursor_q) >> 1;
	assign e_last    = ((ecnt_q + MAXC_W'(1)) == maxc_q) || (above == '0);
	assign enum_emit = cmd.enum_step && occ_vec[cursor_q] && out_free;

	assign stat.out_free  = out_free;
	assign stat.to_enum   = to_enum;
	assign stat.enum_last = enum_emit && e_last;

	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = hit_idx;
		wr_key   = '0;
		wr_val   = '0;
		clr_all  = 1'b0;
		occ_inc  = 1'b0;
		occ_dec  = 1'b0;
		res_ok   = 1'b0;
		res_peer = '0;
		res_occ  = '0;
		case (op_q)
			OP_BIND: begin
				if (child_nz && peer_nz && (hit || has_free)) begin
					wr_en   = 1'b1;
					wr_idx  = hit ? hit_idx : free_idx;
					wr_key  = child_q;
					wr_val  = peer_q;
					occ_inc = !hit;
					res_ok  = 1'b1;
				end
			end
			OP_UNBIND: begin
				// a zero key would match free slots, so it is rejected first
				if (child_nz && hit) begin
					wr_en   = 1'b1;
					occ_dec = 1'b1;
					res_ok  = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (child_nz && hit) begin
					res_ok   = 1'b1;
					res_peer = val_q[hit_idx];
				end
			end
			OP_COUNT: begin
				res_ok  = 1'b1;
				res_occ = occ_disp;
			end
			OP_CLEAR: begin
				clr_all = 1'b1;
				res_ok  = 1'b1;
			end
			default: begin
				// empty enumerate and unused codes fail with all fields zero
			end
		endcase
	end

	// input capture and key compare
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(s_tdata[OP_W-1:0]);
			child_q <= in_child;
			peer_q  <= s_tdata[OP_W + KEY_W +: KEY_W];
			maxc_q  <= (in_maxc > MAXC_CAP) ? MAXC_CAP : in_maxc;
			for (int i = 0; i < SLOTS; i++) begin
				match_q[i] <= (key_q[i] == in_child);
				free_q[i]  <= (key_q[i] == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				key_q[i] <= '0;
				val_q[i] <= '0;
			end
			occ_q <= '0;
		end else if (exec_do) begin
			if (clr_all) begin
				for (int i = 0; i < SLOTS; i++) begin
					key_q[i] <= '0;
					val_q[i] <= '0;
				end
				occ_q <= '0;
			end else begin
				if (wr_en) begin
					key_q[wr_idx] <= wr_key;
					val_q[wr_idx] <= wr_val;
				end
				if (occ_inc) begin
					occ_q <= occ_q + OCC_W'(1);
				end else if (occ_dec) begin
					occ_q <= occ_q - OCC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			ecnt_q   <= '0;
		end else if (cmd.exec && to_enum) begin
			cursor_q <= '0;
			ecnt_q   <= '0;
		end else if (cmd.enum_step) begin
			// free slots are skipped; an occupied one waits for the output
			if (!occ_vec[cursor_q] || out_free) begin
				cursor_q <= cursor_q + IDX_W'(1);
			end
			if (enum_emit) begin
				ecnt_q <= ecnt_q + MAXC_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec_do || enum_emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_do) begin
			ok_q    <= res_ok;
			och_q   <= '0;
			ope_q   <= res_peer;
			oocc_q  <= res_occ;
			olast_q <= 1'b1;
		end else if (enum_emit) begin
			ok_q    <= 1'b1;
			och_q   <= key_q[cursor_q];
			ope_q   <= val_q[cursor_q];
			oocc_q  <= '0;
			olast_q <= e_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, oocc_q, ope_q, och_q, ok_q};
	assign m_tlast  = olast_q;

endmodule

// ===== rtl/key_value_binding_table_core.sv =====
// Key/value binding table: a fixed set of slots mapping nonzero child keys to peer values.
//
// Input stream (s_t*): one word per operation: bind, unbind, lookup, enumerate,
// count or clear. Output stream (m_t*): result words; m_tlast marks the final
// word of each operation. Every operation gives exactly one word except an
// enumerate that finds entries, which gives one word per emitted entry.
// Searches for a key or a free slot always take the lowest matching slot.
// Flow: s_tready is high only while no operation is in progress. An accepted
// word has its keys compared against all slots on the accept edge and its
// result loaded into the output register from the execute state once that
// register is free, so no new word is taken before then. An enumerate walks
// the slots one per cycle from slot 0, pausing at an occupied slot while the
// output register is full, and returns to idle when it loads its last word.
// Stall: while m_tvalid is high and m_tready low the result is held and the
// sequencer waits; no input is taken until the operation has issued its
// last word into the output register.
// Reset (arst_n low): every slot is freed, the occupancy count is zero and
// the output is empty.
module key_value_binding_table_core import kvbt_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // op[2:0], child_id, peer_id, max_count
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // ok, entry_child, entry_peer, occupied
	output logic                   m_tlast
);

	cmd_t  cmd;
	stat_t stat;

	kvbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kvbt_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== dv/tb_key_value_binding_table_core.sv =====
// Self-checking bench for key_value_binding_table_core: directed table, then random ops.
`timescale 1ns / 1ps

module tb_key_value_binding_table_core;
	import kvbt_pkg::*;

	localparam int N_SLOTS = 8;
	localparam int DIR_N = 28;
	localparam int RAND_N = 302;
	localparam int PAUSE_AT = 160;
	localparam int IDLE_LIMIT = 1000;
	localparam int TAIL_CYCLES = 20;
	// opcodes the block must answer with a plain failure
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

	typedef struct packed {
		logic ok;
		logic [KEY_W-1:0] child;
		logic [KEY_W-1:0] peer;
		logic [OCCD_W-1:0] occ;
		logic last;
	} kv_word_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] child;
		logic [KEY_W-1:0] peer;
		logic [MAXC_W-1:0] maxc;
		logic fixed;              // expected word given in the row
		logic e_ok;
		logic [KEY_W-1:0] e_child;
		logic [KEY_W-1:0] e_peer;
		logic [OCCD_W-1:0] e_occ;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tlast;

	logic calm = 1'b0;
	int errors = 0;
	int idle_cycles = 0;
	int stall_left = 0;

	logic [KEY_W-1:0] bound_key [N_SLOTS];
	logic [KEY_W-1:0] bound_peer [N_SLOTS];
	kv_word_t expected_words [$];
	logic [KEY_W-1:0] key_pool [12];

	dir_row_t dir_rows [DIR_N] = '{
		'{OP_LOOKUP, 32'h1, 32'h0, 4'd0, 1'b1, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_COUNT, 32'h0, 32'h0, 4'd0, 1'b1, 1'b1, 32'h0, 32'h0, 4'd0},
		'{OP_ENUM, 32'h0, 32'h0, 4'd8, 1'b1, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_UNBIND, 32'h5, 32'h0, 4'd0, 1'b1, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h0, 32'h7, 4'd0, 1'b1, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h7, 32'h0, 4'd0, 1'b1, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b1, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h1, 32'h11, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h2, 32'h22, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_ENUM, 32'h0, 32'h0, 4'd0, 1'b1, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_ENUM, 32'h0, 32'h0, 4'd15, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_UNBIND, 32'h1, 32'h0, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h8000_0000, 32'h0000_0001, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h3, 32'h33, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h4, 32'h44, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h5, 32'h55, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h6, 32'h66, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h7, 32'h77, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_BIND, 32'h9, 32'h99, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_COUNT, 32'h0, 32'h0, 4'd0, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_ENUM, 32'h0, 32'h0, 4'd9, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_ENUM, 32'h0, 32'h0, 4'd3, 1'b0, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_SPARE6, 32'h2, 32'h2, 4'd8, 1'b1, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_SPARE7, 32'h2, 32'h2, 4'd8, 1'b1, 1'b0, 32'h0, 32'h0, 4'd0},
		'{OP_CLEAR, 32'h0, 32'h0, 4'd0, 1'b1, 1'b1, 32'h0, 32'h0, 4'd0},
		'{OP_COUNT, 32'h0, 32'h0, 4'd0, 1'b1, 1'b1, 32'h0, 32'h0, 4'd0}
	};

	key_value_binding_table_core #(.SLOTS(N_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void push_word(logic ok, logic [KEY_W-1:0] ch, logic [KEY_W-1:0] pe,
			logic [OCCD_W-1:0] occ, logic last);
		kv_word_t w;
		w.ok = ok;
		w.child = ch;
		w.peer = pe;
		w.occ = occ;
		w.last = last;
		expected_words.push_back(w);
	endfunction

	// Table model: updates the slot copy and queues the words one op produces.
	function automatic void apply_table_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] child,
			logic [KEY_W-1:0] peer, logic [MAXC_W-1:0] maxc);
		int hit;
		int hole;
		int n;
		int lim;
		int total;
		hit = -1;
		hole = -1;
		n = 0;
		total = 0;
		for (int i = N_SLOTS - 1; i >= 0; i--) begin
			if (bound_key[i] == child) hit = i;
			if (bound_key[i] == '0) hole = i;
		end
		case (op)
			OP_BIND: begin
				if (child == '0 || peer == '0) begin
					push_word(1'b0, '0, '0, '0, 1'b1);
				end else begin
					if (hit < 0) hit = hole;
					if (hit < 0) begin
						push_word(1'b0, '0, '0, '0, 1'b1);
					end else begin
						bound_key[hit] = child;
						bound_peer[hit] = peer;
						push_word(1'b1, '0, '0, '0, 1'b1);
					end
				end
			end
			OP_UNBIND: begin
				if (child == '0 || hit < 0) begin
					push_word(1'b0, '0, '0, '0, 1'b1);
				end else begin
					bound_key[hit] = '0;
					bound_peer[hit] = '0;
					push_word(1'b1, '0, '0, '0, 1'b1);
				end
			end
			OP_LOOKUP: begin
				if (child == '0 || hit < 0) push_word(1'b0, '0, '0, '0, 1'b1);
				else push_word(1'b1, '0, bound_peer[hit], '0, 1'b1);
			end
			OP_ENUM: begin
				lim = (maxc > MAXC_CAP) ? int'(MAXC_CAP) : int'(maxc);
				for (int i = 0; i < N_SLOTS; i++) begin
					if (bound_key[i] != '0 && n < lim) begin
						push_word(1'b1, bound_key[i], bound_peer[i], '0, 1'b0);
						n++;
					end
				end
				if (n == 0) push_word(1'b0, '0, '0, '0, 1'b1);
				else expected_words[expected_words.size() - 1].last = 1'b1;
			end
			OP_COUNT: begin
				for (int i = 0; i < N_SLOTS; i++)
					if (bound_key[i] != '0) total++;
				if (total > int'(OCC_SAT)) total = int'(OCC_SAT);
				push_word(1'b1, '0, '0, OCCD_W'(total), 1'b1);
			end
			OP_CLEAR: begin
				for (int i = 0; i < N_SLOTS; i++) begin
					bound_key[i] = '0;
					bound_peer[i] = '0;
				end
				push_word(1'b1, '0, '0, '0, 1'b1);
			end
			default: push_word(1'b0, '0, '0, '0, 1'b1);
		endcase
	endfunction

	// Presents one request word after a random gap and waits for the handshake.
	task automatic issue_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] child,
			logic [KEY_W-1:0] peer, logic [MAXC_W-1:0] maxc);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, maxc, peer, child, op};
		do @(posedge clk); while (!s_tready);
		apply_table_op(op, child, peer, maxc);
	endtask

	// receiver backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) stall_left = calm ? 0 : $urandom_range(0, 17);
			else if (stall_left > 0) stall_left--;
			m_tready <= (stall_left == 0);
		end
	end

	// result checker
	always @(posedge clk) begin
		kv_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result word: tdata=%h tlast=%b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (m_tdata[0] !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, m_tdata[0]);
					errors++;
				end
				if (m_tdata[32:1] !== want.child) begin
					$error("entry_child: expected %h, got %h", want.child, m_tdata[32:1]);
					errors++;
				end
				if (m_tdata[64:33] !== want.peer) begin
					$error("entry_peer: expected %h, got %h", want.peer, m_tdata[64:33]);
					errors++;
				end
				if (m_tdata[68:65] !== want.occ) begin
					$error("occupied: expected %0d, got %0d", want.occ, m_tdata[68:65]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] child;
		logic [KEY_W-1:0] peer;
		logic [MAXC_W-1:0] maxc;
		int pick;
		kv_word_t fixed_word;

		for (int i = 0; i < N_SLOTS; i++) begin
			bound_key[i] = '0;
			bound_peer[i] = '0;
		end
		foreach (key_pool[i]) begin
			do key_pool[i] = $urandom; while (key_pool[i] == '0);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_N; r++) begin
			calm = (r < 6);
			issue_request(dir_rows[r].op, dir_rows[r].child, dir_rows[r].peer, dir_rows[r].maxc);
			if (dir_rows[r].fixed) begin
				// fixed rows give a single word; the model still tracks state
				void'(expected_words.pop_back());
				fixed_word.ok = dir_rows[r].e_ok;
				fixed_word.child = dir_rows[r].e_child;
				fixed_word.peer = dir_rows[r].e_peer;
				fixed_word.occ = dir_rows[r].e_occ;
				fixed_word.last = 1'b1;
				expected_words.push_back(fixed_word);
			end
		end

		for (int k = 0; k < RAND_N; k++) begin
			if (k % 30 == 0) calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 35) op = OP_BIND;
			else if (pick < 50) op = OP_UNBIND;
			else if (pick < 70) op = OP_LOOKUP;
			else if (pick < 84) op = OP_ENUM;
			else if (pick < 94) op = OP_COUNT;
			else if (pick < 97) op = OP_CLEAR;
			else op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
			pick = $urandom_range(0, 99);
			if (pick < 85) child = key_pool[$urandom_range(0, 11)];
			else if (pick < 93) child = $urandom;
			else child = '0;
			peer = ($urandom_range(0, 19) == 0) ? '0 : $urandom;
			pick = $urandom_range(0, 9);
			if (pick == 0) maxc = '0;
			else if (pick == 1) maxc = MAXC_W'($urandom_range(9, 15));
			else maxc = MAXC_W'($urandom_range(1, 8));
			issue_request(op, child, peer, maxc);
			if (k == PAUSE_AT) begin
				s_tvalid <= 1'b0;
				while (expected_words.size() != 0) @(posedge clk);
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
